>>> design/mar_pkg.sv
// Shared types, constants and the 2^(-2^-k) table for the Metropolis decision block.
`timescale 1ns / 1ps
`default_nettype none

package mar_pkg;

	localparam int ENERGY_WIDTH_DEF = 32;
	localparam int RANDOM_BITS_DEF  = 16;

	// log2(e) in Q16.16
	localparam logic [31:0] LOG2E_Q16 = 32'd94548;
	// exp ratio limit, integer part of Q16.16: at or above this, probability is zero
	localparam logic [5:0] RATIO_LIMIT = 6'd23;
	// temperature after reset, 1.0 in Q16.16
	localparam logic [31:0] TEMP_RESET = 32'h0001_0000;

	typedef struct packed {
		logic [9:0]         context_index;
		logic [7:0]         block_index;
		logic [9:0]         new_block_type;
		logic signed [31:0] current_energy_term;
		logic signed [31:0] alternate_energy_term;
		logic [15:0]        random_fraction;
		logic               last_term;
	} term_t;

	typedef struct packed {
		logic [9:0]         context_out;
		logic [7:0]         block_out;
		logic [9:0]         block_type_out;
		logic               accepted;
		logic signed [31:0] energy_delta;
	} decision_t;

	// floor(2^32 * 2^(-2^-k)), k = 1..16
	function automatic logic [31:0] pow2_frac(input logic [4:0] k);
		logic [31:0] v;
		unique case (k)
			5'd1:  v = 32'd3037000499;
			5'd2:  v = 32'd3611622602;
			5'd3:  v = 32'd3938502375;
			5'd4:  v = 32'd4112874773;
			5'd5:  v = 32'd4202935003;
			5'd6:  v = 32'd4248701965;
			5'd7:  v = 32'd4271771996;
			5'd8:  v = 32'd4283353945;
			5'd9:  v = 32'd4289156690;
			5'd10: v = 32'd4292061009;
			5'd11: v = 32'd4293513907;
			5'd12: v = 32'd4294240540;
			5'd13: v = 32'd4294603902;
			5'd14: v = 32'd4294785595;
			5'd15: v = 32'd4294876444;
			5'd16: v = 32'd4294921870;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> design/metropolis_accept_reject.sv
// Metropolis accept/reject: term accumulation, sequenced divide and exp, decision output.
// Usage
//   Term channel (term_valid / term_stall / term): one word per energy-term pair.
//   Each word adds its current and alternate terms into two saturating sums.
//   A word with last_term set closes the group and starts the decision.
//   Decision channel (decision_valid / decision_stall / decision): one word per group.
//   Config: cfg_wr_en writes cfg_wr_data into the temperature register (Q16.16);
//   write only while the block is idle. Zero temperature acts as 1 LSB.
// Sequence
//   A word without last_term leaves the block idle; it is ready for the next word.
//   A last word first forms delta and checks the range; when delta <= 0 or the ratio is out of range
//   it goes straight to the output step, else through 21 restoring-divide steps on one 33-bit subtractor,
//   then 17 passes through one shared 32x32 multiplier (log2(e) scale, 16 exp steps),
//   then a final step that forms the probability and loads the output word.
//   The decision sits in an output register; further terms are taken while it waits.
// Reset
//   Sums clear, temperature returns to 1.0, the output register empties.
// Back-pressure
//   While decision_stall holds a waiting word, the next decision waits in its final
//   step and term_stall stays high until that word has moved.
`timescale 1ns / 1ps
`default_nettype none

module metropolis_accept_reject #(
	parameter int ENERGY_WIDTH = mar_pkg::ENERGY_WIDTH_DEF,
	parameter int RANDOM_BITS  = mar_pkg::RANDOM_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [31:0]       cfg_wr_data,
	input  wire logic              term_valid,
	output logic                   term_stall,
	input  wire mar_pkg::term_t    term,
	output logic                   decision_valid,
	input  wire logic              decision_stall,
	output mar_pkg::decision_t     decision
);
	import mar_pkg::*;

	localparam int EW = ENERGY_WIDTH;
	localparam int RB = RANDOM_BITS;
	// sum width with headroom for one 32-bit term
	localparam int SW = ((EW > 32) ? EW : 32) + 1;
	// width for clamping delta to the 32-bit output
	localparam int XW = (EW > 32) ? EW : 32;
	// width for the range check against 23 * T
	localparam int LW = (EW > 37) ? EW : 37;
	localparam int RMB = (RB < 16) ? RB : 16;
	localparam logic [15:0] RND_MASK = 16'((33'd1 << RMB) - 33'd1);

	localparam logic signed [SW-1:0] EMAX = SW'((66'sd1 <<< (EW - 1)) - 66'sd1);
	localparam logic signed [SW-1:0] EMIN = ~EMAX;
	localparam logic signed [XW-1:0] DMAX = XW'(34'sd2147483647);
	localparam logic signed [XW-1:0] DMIN = ~DMAX;

	localparam logic [4:0] DIV_LAST = 5'd20;
	localparam logic [4:0] EXP_LAST = 5'd16;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b000_0001,
		ST_DELTA = 7'b000_0010,
		ST_CHK   = 7'b000_0100,
		ST_DIV   = 7'b000_1000,
		ST_MULY  = 7'b001_0000,
		ST_EXP   = 7'b010_0000,
		ST_FIN   = 7'b100_0000
	} state_t;

	function automatic logic signed [EW-1:0] sat_e(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		if (v > EMAX)
			r = EMAX;
		else if (v < EMIN)
			r = EMIN;
		else
			r = v;
		return r[EW-1:0];
	endfunction

	// control state
	state_t                state_q;
	logic [4:0]            cnt_q;
	logic signed [EW-1:0]  cur_q;
	logic signed [EW-1:0]  alt_q;
	logic [31:0]           temp_q;
	logic                  out_valid_q;
	logic                  a_one_q;
	logic                  big_q;

	// payload
	logic [9:0]            ctx_q;
	logic [7:0]            blk_q;
	logic [9:0]            btype_q;
	logic [15:0]           rnd_q;
	logic signed [EW-1:0]  delta_q;
	logic [32:0]           rem_q;
	logic [20:0]           dbits_q;
	logic [20:0]           quo_q;
	logic [5:0]            n_q;
	logic [15:0]           fr_q;
	logic [31:0]           a_q;
	decision_t             out_q;

	logic                  term_fire;
	logic                  dec_fire;
	logic                  out_free;
	logic [31:0]           t_eff;
	logic signed [EW-1:0]  cur_nxt;
	logic signed [EW-1:0]  alt_nxt;
	logic signed [EW-1:0]  delta_nxt;
	logic                  nonpos;
	logic [LW-1:0]         d_mag;
	logic [36:0]           lim;
	logic                  big;
	logic [32:0]           rem_sh;
	logic [32:0]           rem_sub;
	logic                  rem_ge;
	logic [31:0]           mul_a;
	logic [31:0]           mul_b;
	logic [63:0]           mul_p;
	logic [32:0]           a_ext;
	logic [32:0]           a_shr;
	logic [32:0]           prob;
	logic                  take;
	logic signed [XW-1:0]  d_ext;
	logic signed [XW-1:0]  d_clip;

	assign term_fire = term_valid && !term_stall;
	assign dec_fire  = out_valid_q && !decision_stall;
	assign out_free  = !out_valid_q || !decision_stall;
	assign term_stall     = (state_q != ST_IDLE);
	assign decision_valid = out_valid_q;
	assign decision       = out_q;

	assign t_eff = (temp_q == 32'd0) ? 32'd1 : temp_q;

	// saturating accumulate and delta
	assign cur_nxt   = sat_e(SW'(cur_q) + SW'(term.current_energy_term));
	assign alt_nxt   = sat_e(SW'(alt_q) + SW'(term.alternate_energy_term));
	assign delta_nxt = sat_e(SW'(alt_q) - SW'(cur_q));

	// range check: q >= 23.0 exactly when delta >= 23 * T
	assign nonpos = delta_q[EW-1] || (delta_q == '0);
	assign d_mag  = LW'($unsigned(delta_q));
	assign lim    = (37'(t_eff) << 4) + (37'(t_eff) << 2) + (37'(t_eff) << 1) + 37'(t_eff);
	assign big    = (d_mag >= LW'(lim));

	// one restoring-divide step; remainder stays below T
	assign rem_sh  = {rem_q[31:0], dbits_q[20]};
	assign rem_ge  = (rem_sh >= {1'b0, t_eff});
	assign rem_sub = rem_sh - {1'b0, t_eff};

	// shared multiplier
	always_comb begin
		if (state_q == ST_MULY) begin
			mul_a = {11'd0, quo_q};
			mul_b = LOG2E_Q16;
		end else begin
			mul_a = a_q;
			mul_b = pow2_frac(cnt_q);
		end
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// probability and decision
	assign a_ext = a_one_q ? 33'h1_0000_0000 : {1'b0, a_q};
	assign a_shr = a_ext >> n_q;
	assign prob  = a_shr >> (32 - RB);

	always_comb begin
		priority if (nonpos)
			take = 1'b1;
		else if (big_q)
			take = 1'b0;
		else
			take = (33'(rnd_q) < prob);
	end

	assign d_ext  = XW'(delta_q);
	assign d_clip = (d_ext > DMAX) ? DMAX : ((d_ext < DMIN) ? DMIN : d_ext);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cur_q       <= '0;
			alt_q       <= '0;
			temp_q      <= TEMP_RESET;
			out_valid_q <= 1'b0;
			a_one_q     <= 1'b0;
			big_q       <= 1'b0;
		end else begin
			if (cfg_wr_en)
				temp_q <= cfg_wr_data;
			// a new word loads as the waiting one leaves
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (dec_fire)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (term_fire) begin
						cur_q <= cur_nxt;
						alt_q <= alt_nxt;
						if (term.last_term)
							state_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					cur_q   <= '0;
					alt_q   <= '0;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					big_q <= big;
					cnt_q <= '0;
					if (nonpos || big)
						state_q <= ST_FIN;
					else
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == DIV_LAST)
						state_q <= ST_MULY;
				end
				ST_MULY: begin
					cnt_q   <= 5'd1;
					a_one_q <= 1'b1;
					state_q <= ST_EXP;
				end
				ST_EXP: begin
					if (fr_q[15])
						a_one_q <= 1'b0;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == EXP_LAST)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (term_fire && term.last_term) begin
					ctx_q   <= term.context_index;
					blk_q   <= term.block_index;
					btype_q <= term.new_block_type;
					rnd_q   <= term.random_fraction & RND_MASK;
				end
			end
			ST_DELTA: delta_q <= delta_nxt;
			ST_CHK: begin
				// dividend is delta * 2^16; quotient fits 21 bits in range
				rem_q   <= 33'(d_mag >> 5);
				dbits_q <= {delta_q[4:0], 16'h0000};
			end
			ST_DIV: begin
				rem_q   <= rem_ge ? rem_sub : rem_sh;
				quo_q   <= {quo_q[19:0], rem_ge};
				dbits_q <= {dbits_q[19:0], 1'b0};
			end
			ST_MULY: begin
				n_q  <= mul_p[37:32];
				fr_q <= mul_p[31:16];
			end
			ST_EXP: begin
				if (fr_q[15])
					a_q <= a_one_q ? mul_b : mul_p[63:32];
				fr_q <= {fr_q[14:0], 1'b0};
			end
			ST_FIN: begin
				if (out_free) begin
					out_q.context_out    <= ctx_q;
					out_q.block_out      <= blk_q;
					out_q.block_type_out <= btype_q;
					out_q.accepted       <= take;
					out_q.energy_delta   <= d_clip[31:0];
				end
			end
			default: ;
		endcase
	end

	// sums are cleared once the closing group has been taken up
	a_sums_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHK |-> cur_q == '0 && alt_q == '0)
		else $error("sums not cleared after group close");

	// a non-positive delta is always accepted
	a_nonpos_accept: assert property (@(posedge clk) disable iff (!arst_n)
		decision_valid && decision.energy_delta <= 0 |-> decision.accepted)
		else $error("non-positive delta rejected");

	// the divider only hands over to the log2(e) scaling step
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |=> state_q == ST_DIV || state_q == ST_MULY)
		else $error("divider left out of sequence");

endmodule

`default_nettype wire
